// ===== rtl/core/tfr_pkg.sv =====
// Shared types, constants and tag rebase function for the tagged FIFO.
`default_nettype none

package tfr_pkg;

  localparam int DEPTH         = 16;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int TAG_W         = 32;
  localparam int ROWS_W        = 16;
  localparam int IDX_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int LOOK_W        = 4;
  localparam int LOOK_CNT_W    = 5;
  localparam int OUT_PAY_W     = 32;

  localparam logic [TAG_W-1:0]  SIGN_BIT   = {1'b1, {(TAG_W-1){1'b0}}};
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(1);

  typedef struct packed {
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic signed [TAG_W-1:0]  time_tag;
    logic signed [TAG_W-1:0]  first_tag;
    logic signed [TAG_W-1:0]  result_tag;
  } entry_t;

  typedef struct packed {
    logic                    push_req;
    logic [31:0]             push_payload;
    logic signed [TAG_W-1:0] push_time_tag;
    logic signed [TAG_W-1:0] push_first_tag;
    logic signed [TAG_W-1:0] push_result_tag;
    logic                    pop_req;
    logic                    shift;
    logic [LOOK_W-1:0]       look_index;
  } item_t;

  typedef struct packed {
    logic                    push_refused;
    logic                    pop_refused;
    logic                    look_valid;
    logic [OUT_PAY_W-1:0]    look_payload;
    logic signed [TAG_W-1:0] look_time_tag;
    logic signed [TAG_W-1:0] look_first_tag;
    logic signed [TAG_W-1:0] look_result_tag;
    logic [LOOK_CNT_W-1:0]   entries_from_look;
    logic [LOOK_CNT_W-1:0]   count_after;
  } result_t;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic pop;    // take the neighbor's entry
    logic load;   // take the pushed entry
    logic shift;  // rebase tags
  } cell_ctrl_t;

  // Subtract rows from a signed tag unless that would pass the minimum.
  // Offset-binary form compares like the signed value.
  function automatic logic [TAG_W-1:0] rebase_tag(input logic [TAG_W-1:0] tag,
                                                  input logic [ROWS_W-1:0] rows);
    logic [TAG_W-1:0] biased;
    logic [TAG_W-1:0] rows_ext;
    biased   = tag ^ SIGN_BIT;
    rows_ext = TAG_W'(rows);
    if (biased >= rows_ext) begin
      biased = biased - rows_ext;
    end
    return biased ^ SIGN_BIT;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tagged_fifo_with_tag_rebase.sv =====
// Top level: tagged FIFO as a shifting row of cells with tag rebase.
`default_nettype none
//
// Channel   Dir   Handshake             Content
// item      in    item_valid/item_stall  push/pop/shift/look request (item_t)
// result    out   result_valid/result_stall  refusals, look data, count (result_t)
// cfg       in    cfg_valid/cfg_ready    rows_per_shift write data
//
// One request is taken per unstalled cycle; its result appears in the output
// register on the next cycle. The cell row is the only state path: cell k always
// holds the entry k places from the head, so a pop moves every cell one step
// toward the head and a push loads the cell right after the last occupied one.
// Reset clears the count and sets rows_per_shift to 1; cell contents are not
// cleared. item_stall is high only while a result waits and result_stall holds.

module tagged_fifo_with_tag_rebase (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire tfr_pkg::item_t             item,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output tfr_pkg::result_t                result,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [tfr_pkg::ROWS_W-1:0] cfg_data
);

  logic [tfr_pkg::ROWS_W-1:0] rows;
  logic [tfr_pkg::CNT_W-1:0]  count;
  logic [tfr_pkg::CNT_W-1:0]  count_next;
  logic [tfr_pkg::CNT_W-1:0]  wr_pos;
  logic                       accept;
  logic                       push_ok;
  logic                       pop_ok;
  logic                       look_ok;
  tfr_pkg::entry_t            push_entry;
  tfr_pkg::entry_t            cells [tfr_pkg::DEPTH];
  tfr_pkg::entry_t            look_entry;
  tfr_pkg::result_t           result_next;

  assign cfg_ready  = 1'b1;
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  // Refusal uses the count at the start of the cycle.
  assign push_ok = accept && item.push_req && (count < tfr_pkg::CNT_W'(tfr_pkg::DEPTH));
  assign pop_ok  = accept && item.pop_req && (count != '0);

  // Pushed entry lands after the pop has moved the row.
  assign wr_pos     = count - tfr_pkg::CNT_W'(pop_ok);
  assign count_next = count + tfr_pkg::CNT_W'(push_ok) - tfr_pkg::CNT_W'(pop_ok);

  always_comb begin
    push_entry.payload    = tfr_pkg::PAYLOAD_WIDTH'(item.push_payload);
    push_entry.time_tag   = item.push_time_tag;
    push_entry.first_tag  = item.push_first_tag;
    push_entry.result_tag = item.push_result_tag;
  end

  for (genvar k = 0; k < tfr_pkg::DEPTH; k++) begin : g_cell
    tfr_pkg::cell_ctrl_t ctrl;
    tfr_pkg::entry_t     neighbor;

    always_comb begin
      ctrl.pop   = pop_ok;
      ctrl.load  = push_ok && (wr_pos == tfr_pkg::CNT_W'(k));
      ctrl.shift = accept && item.shift;
    end

    // Last cell has no neighbor; what it takes on a pop is beyond the count.
    if (k == tfr_pkg::DEPTH - 1) begin : g_last
      assign neighbor = push_entry;
    end else begin : g_mid
      assign neighbor = cells[k + 1];
    end

    tfr_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .rows       (rows),
      .push_entry (push_entry),
      .neighbor   (neighbor),
      .entry      (cells[k])
    );
  end

  // Look sees the row as it stood before this cycle.
  assign look_ok    = tfr_pkg::CNT_W'(item.look_index) < count;
  assign look_entry = cells[item.look_index[tfr_pkg::IDX_W-1:0]];

  always_comb begin
    result_next                   = '0;
    result_next.push_refused      = item.push_req && !push_ok;
    result_next.pop_refused       = item.pop_req && !pop_ok;
    result_next.look_valid        = look_ok;
    result_next.count_after       = tfr_pkg::LOOK_CNT_W'(count_next);
    if (look_ok) begin
      result_next.look_payload      = tfr_pkg::OUT_PAY_W'(look_entry.payload);
      result_next.look_time_tag     = look_entry.time_tag;
      result_next.look_first_tag    = look_entry.first_tag;
      result_next.look_result_tag   = look_entry.result_tag;
      result_next.entries_from_look = tfr_pkg::LOOK_CNT_W'(count - tfr_pkg::CNT_W'(item.look_index));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      rows         <= tfr_pkg::ROWS_RESET;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rows <= cfg_data;
      end
      if (accept) begin
        count        <= count_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload register, loaded only on an accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tfr_cell.sv =====
// One FIFO cell: holds the entry at a fixed distance from the head.
`default_nettype none

module tfr_cell (
  input  wire logic                       clk,
  input  wire tfr_pkg::cell_ctrl_t        ctrl,
  input  wire logic [tfr_pkg::ROWS_W-1:0] rows,
  input  wire tfr_pkg::entry_t            push_entry,
  input  wire tfr_pkg::entry_t            neighbor,
  output tfr_pkg::entry_t                 entry
);

  tfr_pkg::entry_t base;
  tfr_pkg::entry_t entry_next;

  always_comb begin
    if (ctrl.load) begin
      base = push_entry;
    end else if (ctrl.pop) begin
      base = neighbor;
    end else begin
      base = entry;
    end
    entry_next = base;
    if (ctrl.shift) begin
      entry_next.time_tag   = tfr_pkg::rebase_tag(base.time_tag, rows);
      entry_next.first_tag  = tfr_pkg::rebase_tag(base.first_tag, rows);
      entry_next.result_tag = tfr_pkg::rebase_tag(base.result_tag, rows);
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire
